>>> rtl/core/json_manifest_keyword_check_unit_macros.svh
// assertion macros for the json manifest keyword check unit
// used by the property module; no other dependencies
`ifndef JSON_MANIFEST_KEYWORD_CHECK_UNIT_MACROS_SVH
`define JSON_MANIFEST_KEYWORD_CHECK_UNIT_MACROS_SVH

// checked only outside reset
`define JMKC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// checked at every edge, reset included
`define JMKC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> rtl/core/jmkc_pkg.sv
// shared types, key constants and the key compare function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jmkc_pkg;

  localparam int unsigned WinDepth = 13;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);
  localparam int unsigned KeyBits  = (WinDepth + 1) * 8;

  typedef logic [WinDepth-1:0][7:0] win_t;
  typedef logic [KeyBits-1:0]       key_t;
  typedef logic [FillW-1:0]         fill_t;

  typedef struct packed {
    logic resources;
    logic tools;
    logic capabilities;
    logic version;
  } hits_t;

  // keys are right aligned: last character in the low byte
  localparam key_t        KeyVerA    = key_t'({"\"mcp", 8'h5f, "version\""});
  localparam int unsigned KeyVerALen = 13;
  localparam key_t        KeyVerB    = key_t'("\"mcpVersion\"");
  localparam int unsigned KeyVerBLen = 12;
  localparam key_t        KeyCaps    = key_t'("\"capabilities\"");
  localparam int unsigned KeyCapsLen = 14;
  localparam key_t        KeyTools   = key_t'("\"tools\"");
  localparam int unsigned KeyToolsLen = 7;
  localparam key_t        KeyRes     = key_t'("\"resources\"");
  localparam int unsigned KeyResLen  = 11;

  // key ends at the current byte, window holds older bytes newest first
  function automatic logic key_hit(win_t win, fill_t fill, logic [7:0] cur,
                                   key_t key, int unsigned len);
    logic hit;
    hit = (fill >= FillW'(len - 1)) && (key[7:0] == cur);
    for (int unsigned i = 0; i < WinDepth; i++) begin
      if (i + 1 < len) begin
        hit = hit && (win[i] == key[8*(i+1) +: 8]);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/jmkc_stream_if.sv
// valid/ready stream interfaces for the input and result channels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface jmkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_body;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_body, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_body, output ready);
endinterface

interface jmkc_out_if;
  logic valid;
  logic ready;
  logic manifest_ok;
  logic saw_version;
  logic saw_capabilities;
  logic saw_tools;
  logic saw_resources;

  modport source (output valid, output manifest_ok, output saw_version,
                  output saw_capabilities, output saw_tools,
                  output saw_resources, input ready);
  modport sink   (input valid, input manifest_ok, input saw_version,
                  input saw_capabilities, input saw_tools,
                  input saw_resources, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jmkc_window.sv
// shift window of recent body bytes with saturating fill count
// depends on jmkc_pkg
`timescale 1ns / 1ps
`default_nettype none

module jmkc_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  logic [7:0]       byte_i,
  output jmkc_pkg::win_t   win_o,
  output jmkc_pkg::fill_t  fill_o
);
  import jmkc_pkg::*;

  win_t  win_q, win_d;
  fill_t fill_q, fill_d;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (clear_i) begin
      win_d  = '0;
      fill_d = '0;
    end else if (shift_i) begin
      win_d = {win_q[WinDepth-2:0], byte_i};
      if (fill_q != FillW'(WinDepth)) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

  assign win_o  = win_q;
  assign fill_o = fill_q;

endmodule

`default_nettype wire

>>> rtl/core/jmkc_matcher.sv
// parallel comparators of the window and current byte against the keys
// depends on jmkc_pkg
`timescale 1ns / 1ps
`default_nettype none

module jmkc_matcher (
  input  jmkc_pkg::win_t   win_i,
  input  jmkc_pkg::fill_t  fill_i,
  input  logic [7:0]       byte_i,
  output jmkc_pkg::hits_t  hits_o
);
  import jmkc_pkg::*;

  always_comb begin
    hits_o.version      = key_hit(win_i, fill_i, byte_i, KeyVerA, KeyVerALen) ||
                          key_hit(win_i, fill_i, byte_i, KeyVerB, KeyVerBLen);
    hits_o.capabilities = key_hit(win_i, fill_i, byte_i, KeyCaps, KeyCapsLen);
    hits_o.tools        = key_hit(win_i, fill_i, byte_i, KeyTools, KeyToolsLen);
    hits_o.resources    = key_hit(win_i, fill_i, byte_i, KeyRes, KeyResLen);
  end

endmodule

`default_nettype wire

>>> rtl/core/json_manifest_keyword_check_unit.sv
// json manifest keyword check: one body byte per beat, verdict on last beat
// result: verdict and valid register as the last beat leaves the input register
// throughput: one beat per cycle via matcher input register, unless a result stalls
// reset: window, fill count, found flags and valid bits clear at once
// depends on jmkc_pkg, jmkc_stream_if, jmkc_window, jmkc_matcher
`timescale 1ns / 1ps
`default_nettype none

module json_manifest_keyword_check_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  jmkc_in_if.sink    in_i,
  jmkc_out_if.source out_o
);
  import jmkc_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_present_q;
  logic       s1_last_q;
  logic       s1_retire;
  logic       s1_load;
  logic       shift_en;
  logic       clear_en;

  win_t  win;
  fill_t fill;
  hits_t hits;
  hits_t found;
  hits_t flags_q, flags_d;

  logic  out_valid_q, out_valid_d;
  hits_t res_q;

  assign s1_retire  = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_retire;
  assign s1_load    = in_i.valid && in_i.ready;
  assign shift_en   = s1_retire && s1_present_q;
  assign clear_en   = s1_retire && s1_last_q;

  jmkc_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift_en),
    .clear_i (clear_en),
    .byte_i  (s1_byte_q),
    .win_o   (win),
    .fill_o  (fill)
  );

  jmkc_matcher u_matcher (
    .win_i  (win),
    .fill_i (fill),
    .byte_i (s1_byte_q),
    .hits_o (hits)
  );

  assign found = s1_present_q ? (flags_q | hits) : flags_q;

  always_comb begin
    flags_d = flags_q;
    if (clear_en) begin
      flags_d = '0;
    end else if (shift_en) begin
      flags_d = found;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (clear_en) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q    <= in_i.data_byte;
      s1_present_q <= in_i.byte_present;
      s1_last_q    <= in_i.end_of_body;
    end
    if (clear_en) begin
      res_q <= found;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.manifest_ok      = res_q.version &&
                                  (res_q.capabilities || res_q.tools || res_q.resources);
  assign out_o.saw_version      = res_q.version;
  assign out_o.saw_capabilities = res_q.capabilities;
  assign out_o.saw_tools        = res_q.tools;
  assign out_o.saw_resources    = res_q.resources;

endmodule

`default_nettype wire

>>> rtl/core/jmkc_props.sv
// port level properties of the keyword check unit, bound to the top level
// depends on json_manifest_keyword_check_unit_macros.svh and the top level
`timescale 1ns / 1ps
`default_nettype none

`include "json_manifest_keyword_check_unit_macros.svh"

module jmkc_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic manifest_ok_i,
  input logic saw_version_i,
  input logic saw_capabilities_i,
  input logic saw_tools_i,
  input logic saw_resources_i
);

  `JMKC_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_i)

  `JMKC_ASSERT(a_verdict, clk_i, rst_ni, out_valid_i |-> (manifest_ok_i == (saw_version_i && (saw_capabilities_i || saw_tools_i || saw_resources_i))))

  `JMKC_ASSERT(a_result_after_last, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))

  `JMKC_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(manifest_ok_i) && $stable(saw_version_i))

endmodule

bind json_manifest_keyword_check_unit jmkc_props u_props (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_last_i          (in_i.end_of_body),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .manifest_ok_i      (out_o.manifest_ok),
  .saw_version_i      (out_o.saw_version),
  .saw_capabilities_i (out_o.saw_capabilities),
  .saw_tools_i        (out_o.saw_tools),
  .saw_resources_i    (out_o.saw_resources)
);

`default_nettype wire
